/* sv/mrf_pkg.sv */
// Types, constants and the CRC step shared by the Modbus request framer.
`default_nettype none
package mrf_pkg;

  localparam int IDX_W = 4;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE1 = 2'd1,
    KIND_WRITE2 = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_t;

  localparam logic [7:0]  FN_READ_REGS  = 8'h03;
  localparam logic [7:0]  FN_WRITE_ONE  = 8'h06;
  localparam logic [7:0]  FN_WRITE_MANY = 8'h10;
  localparam logic [7:0]  BYTE_ZERO     = 8'h00;
  localparam logic [7:0]  WM_QTY        = 8'h02;
  localparam logic [7:0]  WM_BYTES      = 8'h04;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  localparam logic [IDX_W-1:0] CRC_IDX_SHORT  = 4'd6;
  localparam logic [IDX_W-1:0] CRC_IDX_LONG   = 4'd11;
  localparam logic [IDX_W-1:0] LAST_IDX_SHORT = 4'd7;
  localparam logic [IDX_W-1:0] LAST_IDX_LONG  = 4'd12;

  localparam logic [2:0] ADDR_WORD_SWAP = 3'd0;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic out_free;
    logic is_last;
  } ctrl_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/mrf_ctrl.sv */
// Controller state machine that sequences the bytes of one frame.
`default_nettype none
module mrf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrf_pkg::ctrl_sts_t sts,
  output mrf_pkg::ctrl_cmd_t cmd
);
  import mrf_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.idx   = idx_r;
    in_stall  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.req_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEND;
          idx_nxt   = '0;
        end
      end
      ST_SEND: begin
        in_stall = 1'b1;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/mrf_dp.sv */
// Datapath: request registers, byte selection, running CRC and output register.
`default_nettype none
module mrf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               word_swap,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_slave_addr,
  input  logic [7:0]         in_register_high,
  input  logic [7:0]         in_register_low,
  input  logic [7:0]         in_reg_count,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  input  mrf_pkg::ctrl_cmd_t cmd,
  output mrf_pkg::ctrl_sts_t sts
);
  import mrf_pkg::*;

  kind_t       kind_r;
  logic [7:0]  slave_r, reg_hi_r, reg_lo_r, count_r;
  logic [31:0] value_r;
  logic [15:0] crc_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic             long_frame;
  logic [IDX_W-1:0] crc_idx, last_idx;
  logic [7:0]       byte_sel;
  logic [31:0]      data_word;

  assign long_frame = (kind_r == KIND_WRITE2);
  assign crc_idx    = long_frame ? CRC_IDX_LONG : CRC_IDX_SHORT;
  assign last_idx   = long_frame ? LAST_IDX_LONG : LAST_IDX_SHORT;
  assign data_word  = word_swap ? {value_r[15:0], value_r[31:16]} : value_r;

  always_comb begin
    byte_sel = BYTE_ZERO;
    if (cmd.idx == crc_idx) begin
      byte_sel = crc_r[7:0];
    end else if (cmd.idx == last_idx) begin
      byte_sel = crc_r[15:8];
    end else begin
      case (cmd.idx)
        4'd0: byte_sel = slave_r;
        4'd1: begin
          case (kind_r)
            KIND_READ:   byte_sel = FN_READ_REGS;
            KIND_WRITE1: byte_sel = FN_WRITE_ONE;
            default:     byte_sel = FN_WRITE_MANY;
          endcase
        end
        4'd2: byte_sel = reg_hi_r;
        4'd3: byte_sel = reg_lo_r;
        4'd4: byte_sel = (kind_r == KIND_WRITE1) ? value_r[15:8] : BYTE_ZERO;
        4'd5: begin
          case (kind_r)
            KIND_READ:   byte_sel = count_r;
            KIND_WRITE1: byte_sel = value_r[7:0];
            default:     byte_sel = WM_QTY;
          endcase
        end
        4'd6:    byte_sel = WM_BYTES;
        4'd7:    byte_sel = data_word[31:24];
        4'd8:    byte_sel = data_word[23:16];
        4'd9:    byte_sel = data_word[15:8];
        4'd10:   byte_sel = data_word[7:0];
        default: byte_sel = BYTE_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      slave_r  <= in_slave_addr;
      reg_hi_r <= in_register_high;
      reg_lo_r <= in_register_low;
      count_r  <= in_reg_count;
      value_r  <= in_write_value;
      crc_r    <= CRC_INIT;
    end else if (cmd.emit && (cmd.idx < crc_idx)) begin
      crc_r <= crc_byte(crc_r, byte_sel);
    end
    if (cmd.emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= (cmd.idx == last_idx);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.req_ok   = (in_kind == KIND_READ) || (in_kind == KIND_WRITE1) ||
                        (in_kind == KIND_WRITE2);
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.is_last  = (cmd.idx == last_idx);

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

/* sv/modbus_request_framer.sv */
// Top level of the Modbus RTU request framer with its configuration register.
//
//   channel  direction  transfer when          carries
//   in_      input      in_valid & !in_stall   one request
//   out_     output     out_valid & !out_stall one frame byte, out_last on the final byte
//   apb      input      psel&penable&pwrite    word_swap at addresses 0-3
//
// A request is taken into the request registers, then the frame leaves at one byte
// per cycle from the output register when the output is not stalled: 8 bytes for
// reads and single writes, 13 for 32-bit writes, as the byte counter sets them.
// A request of the unused kind is taken and produces nothing.
// Stalls on the output hold the current byte and pause the frame; in_stall stays
// high until the final byte is in the output register. Reset is synchronous.
`default_nettype none
module modbus_request_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_slave_addr,
  input  logic [7:0]         in_register_high,
  input  logic [7:0]         in_register_low,
  input  logic [7:0]         in_reg_count,
  input  logic signed [31:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mrf_pkg::*;

  logic       word_swap_r;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_swap_r <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_WORD_SWAP[2])) begin
      word_swap_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_WORD_SWAP[2]) ? {31'd0, word_swap_r} : 32'd0;

  mrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .word_swap        (word_swap_r),
    .in_kind          (in_kind),
    .in_slave_addr    (in_slave_addr),
    .in_register_high (in_register_high),
    .in_register_low  (in_register_low),
    .in_reg_count     (in_reg_count),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
`default_nettype wire

/* sv/mrf_checker.sv */
// Port-level checks for the Modbus request framer and their binding.
`default_nettype none
module mrf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_kind,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_byte,
  input logic               out_last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);
  import mrf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output byte changed");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    ((in_kind == KIND_READ) || (in_kind == KIND_WRITE1) || (in_kind == KIND_WRITE2))
    |=> in_stall)
    else $error("request transfer did not start a frame");

  a_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid && out_last)
    else $error("input freed before the final frame byte");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=> paddr[2] || prdata[0] == $past(pwdata[0]))
    else $error("word_swap readback mismatch");

endmodule

bind modbus_request_framer mrf_checker u_mrf_checker (.*);
`default_nettype wire

/* verif/modbus_request_framer_tb.sv */
// Self-checking testbench for the Modbus RTU request framer: random requests, frame bytes checked.
`default_nettype none
module modbus_request_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrf_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_MAX = 18;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int FRAME_MAX = 13;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  class frame_scoreboard;
    frame_byte_t pending_bytes[$];
    bit          word_swap;
    int          failures;
    logic [7:0]  frame_buf[FRAME_MAX];
    int          frame_len;

    function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      repeat (8) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void put_byte(logic [7:0] b);
      frame_buf[frame_len] = b;
      frame_len++;
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] slave, logic [7:0] reg_hi,
                               logic [7:0] reg_lo, logic [7:0] count, logic [31:0] value);
      logic [15:0] crc;
      frame_byte_t fb;
      frame_len = 0;
      put_byte(slave);
      case (kind)
        KIND_READ: begin
          put_byte(FN_READ_REGS);
          put_byte(reg_hi);
          put_byte(reg_lo);
          put_byte(BYTE_ZERO);
          put_byte(count);
        end
        KIND_WRITE1: begin
          put_byte(FN_WRITE_ONE);
          put_byte(reg_hi);
          put_byte(reg_lo);
          put_byte(value[15:8]);
          put_byte(value[7:0]);
        end
        KIND_WRITE2: begin
          put_byte(FN_WRITE_MANY);
          put_byte(reg_hi);
          put_byte(reg_lo);
          put_byte(BYTE_ZERO);
          put_byte(WM_QTY);
          put_byte(WM_BYTES);
          if (word_swap) begin
            put_byte(value[15:8]);
            put_byte(value[7:0]);
            put_byte(value[31:24]);
            put_byte(value[23:16]);
          end else begin
            put_byte(value[31:24]);
            put_byte(value[23:16]);
            put_byte(value[15:8]);
            put_byte(value[7:0]);
          end
        end
        default: return;
      endcase
      crc = CRC_INIT;
      for (int i = 0; i < frame_len; i++) crc = crc16_update(crc, frame_buf[i]);
      put_byte(crc[7:0]);
      put_byte(crc[15:8]);
      for (int i = 0; i < frame_len; i++) begin
        fb.data = frame_buf[i];
        fb.last = (i == frame_len - 1);
        pending_bytes.insert(pending_bytes.size(), fb);
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t fb;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none actual %02h last %0b",
                 $time, data, last);
        failures++;
        return;
      end
      fb = pending_bytes.pop_front();
      if (data !== fb.data) begin
        $display("%0t: out_byte mismatch, expected %02h actual %02h", $time, fb.data, data);
        failures++;
      end
      if (last !== fb.last) begin
        $display("%0t: out_last mismatch, expected %0b actual %0b", $time, fb.last, last);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_slave_addr = '0;
  logic [7:0]  in_register_high = '0;
  logic [7:0]  in_register_low = '0;
  logic [7:0]  in_reg_count = '0;
  logic [31:0] in_write_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb;
  bit              no_idle = 1'b0;
  int              cycles = 0;

  modbus_request_framer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_slave_addr(in_slave_addr), .in_register_high(in_register_high),
    .in_register_low(in_register_low), .in_reg_count(in_reg_count),
    .in_write_value(in_write_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic int draw_idle();
    return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [7:0] slave,
                              input logic [7:0] reg_hi, input logic [7:0] reg_lo,
                              input logic [7:0] count, input logic [31:0] value);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_slave_addr    <= slave;
    in_register_high <= reg_hi;
    in_register_low  <= reg_lo;
    in_reg_count     <= count;
    in_write_value   <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, slave, reg_hi, reg_lo, count, value);
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    int         sent;
    int         pick;
    logic [1:0] kind;
    sent = 0;
    while (sent < n) begin
      if (sent % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = KIND_READ;
      else if (pick < 60) kind = KIND_WRITE1;
      else if (pick < 92) kind = KIND_WRITE2;
      else kind = KIND_UNUSED;
      send_request(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
      if (kind != KIND_UNUSED) sent++;
    end
    no_idle = 1'b0;
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_word_swap(input bit swap);
    logic [31:0] rdata;
    drain();
    apb_access(1'b1, ADDR_WORD_SWAP, {31'b0, swap}, rdata);
    sb.word_swap = swap;
    apb_access(1'b0, ADDR_WORD_SWAP, '0, rdata);
    if (rdata[0] !== swap) begin
      $display("%0t: word_swap readback mismatch, expected %0b actual %0b",
               $time, swap, rdata[0]);
      sb.failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte(out_byte, out_last);
  end

  initial begin
    int hold;
    wait (rst_n);
    @(negedge clk);
    forever begin
      hold = draw_idle();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(KIND_READ, 8'h00, 8'h00, 8'h00, 8'h00, $urandom);
    send_request(KIND_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, $urandom);
    send_request(KIND_WRITE1, 8'h00, 8'h00, 8'h00, 8'($urandom), 32'h0000_0000);
    send_request(KIND_WRITE1, 8'hFF, 8'hFF, 8'hFF, 8'($urandom), 32'hFFFF_FFFF);
    send_request(KIND_WRITE1, 8'h01, 8'h80, 8'h01, 8'($urandom), 32'h7FFF_8000);
    send_request(KIND_WRITE2, 8'h00, 8'h00, 8'h00, 8'($urandom), 32'h0000_0000);
    send_request(KIND_WRITE2, 8'hFF, 8'hFF, 8'hFF, 8'($urandom), 32'hFFFF_FFFF);
    send_request(KIND_WRITE2, 8'h11, 8'hAB, 8'hCD, 8'($urandom), 32'h8000_0000);
    send_request(KIND_WRITE2, 8'h7F, 8'h40, 8'h02, 8'($urandom), 32'h7FFF_FFFF);
    send_request(KIND_WRITE2, 8'h05, 8'h12, 8'h34, 8'($urandom), 32'h1234_5678);
    send_request(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom);
    send_request(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom);
    send_request(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);

    set_word_swap(1'b1);
    send_request(KIND_WRITE2, 8'h05, 8'h12, 8'h34, 8'($urandom), 32'h1234_5678);
    send_request(KIND_WRITE2, 8'hFF, 8'h00, 8'hFF, 8'($urandom), 32'h8000_0000);
    send_request(KIND_WRITE2, 8'h00, 8'hFF, 8'h00, 8'($urandom), 32'h0000_FFFF);
    send_request(KIND_WRITE1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom);
    send_request(KIND_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 $urandom);
    send_random(115);

    set_word_swap(1'b0);
    send_random(110);

    set_word_swap(1'b1);
    send_random(110);

    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.failures == 0 && sb.pending_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
